/* design/mqs_pkg.sv */
// Shared types and constants for the multi-queue shared store.
package mqs_pkg;

   localparam int DATA_W = 32;
   localparam int QID_W  = 2;
   localparam int STAT_W = 2;

   localparam logic OP_ENQ = 1'b0;
   localparam logic OP_DEQ = 1'b1;

   localparam logic [STAT_W-1:0] STATUS_OK    = 2'd0;
   localparam logic [STAT_W-1:0] STATUS_FULL  = 2'd1;
   localparam logic [STAT_W-1:0] STATUS_EMPTY = 2'd2;

   typedef struct packed {
      logic capture;
      logic execute;
      logic load_rsp;
   } cmd_type;

endpackage

/* design/mqs_req_if.sv */
// Request channel: operation, queue number and data word.
interface mqs_req_if import mqs_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic                     op;
   logic [QID_W-1:0]         queue_id;
   logic signed [DATA_W-1:0] value;

   modport source (output valid, output op, output queue_id, output value, input ready);
   modport sink   (input valid, input op, input queue_id, input value, output ready);
endinterface

/* design/mqs_rsp_if.sv */
// Response channel: status code and dequeued word.
interface mqs_rsp_if import mqs_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic [STAT_W-1:0]        status;
   logic signed [DATA_W-1:0] data;

   modport source (output valid, output status, output data, input ready);
   modport sink   (input valid, input status, input data, output ready);
endinterface

/* design/mqs_ctrl.sv */
// Sequencer: accept a beat, run it through the datapath, hand off the result.
module mqs_ctrl import mqs_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output cmd_type cmd
);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_EXEC = 2'd1;
   localparam logic [1:0] ST_POST = 2'd2;

   logic [1:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       out_free;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in     = state_ff;
      cmd.capture  = 1'b0;
      cmd.execute  = 1'b0;
      cmd.load_rsp = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = ST_EXEC;
            end
         end
         ST_EXEC: begin
            cmd.execute = 1'b1;
            state_in    = ST_POST;
         end
         ST_POST: begin
            // hold until the output register is free
            if (out_free) begin
               cmd.load_rsp = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

/* design/mqs_datapath.sv */
// Queue pointers, shared word store and result registers.
module mqs_datapath import mqs_pkg::*; #(
   parameter int NUM_QUEUES = 4,
   parameter int SEG_DEPTH  = 16
) (
   input  logic                     clock,
   input  logic                     reset,
   input  cmd_type                  cmd,
   input  logic                     req_op,
   input  logic [QID_W-1:0]         req_queue_id,
   input  logic signed [DATA_W-1:0] req_value,
   output logic [STAT_W-1:0]        rsp_status,
   output logic signed [DATA_W-1:0] rsp_data
);

   localparam int OFF_W  = $clog2(SEG_DEPTH);
   localparam int QIX_W  = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
   localparam int WORDS  = NUM_QUEUES * SEG_DEPTH;
   localparam int ADDR_W = $clog2(WORDS);

   // captured request
   logic                     op_ff;
   logic [QID_W-1:0]         qid_ff;
   logic signed [DATA_W-1:0] value_ff;

   // per-queue state
   logic [OFF_W-1:0] head_ff [NUM_QUEUES];
   logic [OFF_W-1:0] tail_ff [NUM_QUEUES];
   logic [OFF_W-1:0] head_in [NUM_QUEUES];
   logic [OFF_W-1:0] tail_in [NUM_QUEUES];
   logic [NUM_QUEUES-1:0] occ_ff, occ_in;

   // shared store
   logic [DATA_W-1:0] store_ff [WORDS];
   logic [DATA_W-1:0] rdata_ff;

   // result pending between execute and hand-off
   logic [STAT_W-1:0] pend_status_ff;
   logic              pend_deq_ok_ff;
   logic [STAT_W-1:0] rsp_status_ff;
   logic [DATA_W-1:0] rsp_data_ff;

   logic              in_range;
   logic [QIX_W-1:0]  qix;
   logic [OFF_W-1:0]  head, tail, next_tail, next_head;
   logic              occ, full;
   logic              enq_first, enq_ok, deq_ok;
   logic [ADDR_W-1:0] base, wr_addr, rd_addr;
   logic [STAT_W-1:0] status_calc;

   assign in_range  = (32'(qid_ff) < 32'(NUM_QUEUES));
   assign qix       = QIX_W'(qid_ff);
   assign head      = head_ff[qix];
   assign tail      = tail_ff[qix];
   assign occ       = occ_ff[qix];
   assign next_tail = (tail == OFF_W'(SEG_DEPTH - 1)) ? '0 : tail + OFF_W'(1);
   assign next_head = (head == OFF_W'(SEG_DEPTH - 1)) ? '0 : head + OFF_W'(1);
   assign full      = occ && (next_tail == head);

   assign enq_first = in_range && (op_ff == OP_ENQ) && !occ;
   assign enq_ok    = in_range && (op_ff == OP_ENQ) && occ && !full;
   assign deq_ok    = in_range && (op_ff == OP_DEQ) && occ;

   assign base    = ADDR_W'(qix) * ADDR_W'(SEG_DEPTH);
   assign wr_addr = base + (enq_first ? ADDR_W'(0) : ADDR_W'(next_tail));
   assign rd_addr = base + ADDR_W'(head);

   always_comb begin
      if (op_ff == OP_ENQ) begin
         status_calc = (enq_first || enq_ok) ? STATUS_OK : STATUS_FULL;
      end else begin
         status_calc = deq_ok ? STATUS_OK : STATUS_EMPTY;
      end
   end

   always_comb begin
      head_in = head_ff;
      tail_in = tail_ff;
      occ_in  = occ_ff;
      if (cmd.execute) begin
         if (enq_first) begin
            head_in[qix] = '0;
            tail_in[qix] = '0;
            occ_in[qix]  = 1'b1;
         end else if (enq_ok) begin
            tail_in[qix] = next_tail;
         end else if (deq_ok) begin
            if (head == tail) begin
               // last word leaves: mark empty and rewind
               occ_in[qix]  = 1'b0;
               head_in[qix] = '0;
               tail_in[qix] = '0;
            end else begin
               head_in[qix] = next_head;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         occ_ff <= '0;
         for (int i = 0; i < NUM_QUEUES; i++) begin
            head_ff[i] <= '0;
            tail_ff[i] <= '0;
         end
      end else begin
         occ_ff  <= occ_in;
         head_ff <= head_in;
         tail_ff <= tail_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff    <= req_op;
         qid_ff   <= req_queue_id;
         value_ff <= req_value;
      end
      if (cmd.execute) begin
         pend_status_ff <= status_calc;
         pend_deq_ok_ff <= deq_ok;
      end
      if (cmd.load_rsp) begin
         rsp_status_ff <= pend_status_ff;
         rsp_data_ff   <= pend_deq_ok_ff ? rdata_ff : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.execute && (enq_first || enq_ok)) begin
         store_ff[wr_addr] <= value_ff;
      end
      if (cmd.execute && deq_ok) begin
         rdata_ff <= store_ff[rd_addr];
      end
   end

   assign rsp_status = rsp_status_ff;
   assign rsp_data   = rsp_data_ff;

endmodule

/* design/multi_queue_shared_store_top.sv */
// Top level: several FIFO queues sharing one word store, one operation per beat.
// Each request runs capture, execute with store access, then hand-off to the output;
//    a new request is accepted only after the previous one has been handed off, and
//    the store read is registered, so the execute step and the hand-off are separate.
// A response waiting in the output register stalls only the hand-off step.
// Reset (synchronous, active high) empties every queue and rewinds its pointers; store
//    words hold no defined value until written and are never read before that.
module multi_queue_shared_store_top import mqs_pkg::*; #(
   parameter int NUM_QUEUES = 4,
   parameter int SEG_DEPTH  = 16
) (
   input  logic      clock,
   input  logic      reset,
   mqs_req_if.sink   req_if,
   mqs_rsp_if.source rsp_if
);

   cmd_type cmd;

   // sequencer: one beat in flight at a time
   mqs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_ready (req_if.ready),
      .rsp_valid (rsp_if.valid),
      .rsp_ready (rsp_if.ready),
      .cmd       (cmd)
   );

   // pointers, store and output payload
   mqs_datapath #(
      .NUM_QUEUES (NUM_QUEUES),
      .SEG_DEPTH  (SEG_DEPTH)
   ) u_datapath (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .req_op       (req_if.op),
      .req_queue_id (req_if.queue_id),
      .req_value    (req_if.value),
      .rsp_status   (rsp_if.status),
      .rsp_data     (rsp_if.data)
   );

endmodule

/* dv/tb_multi_queue_shared_store_top.sv */
// Self-checking testbench for the multi-queue shared store: directed table, then random traffic.
module tb_multi_queue_shared_store_top;
   import mqs_pkg::*;

   localparam int NUM_QUEUES       = 4;
   localparam int SEG_DEPTH        = 16;
   localparam int RANDOM_ITEMS     = 1300;
   localparam int HOLD_OFF_CYCLES  = 400;
   localparam int WATCHDOG_LIMIT   = 3000;
   localparam int DRAIN_CYCLES     = 8;
   localparam int NUM_ROWS         = 14;

   // One response beat as the block should produce it.
   typedef struct packed {
      logic [STAT_W-1:0]        status;
      logic signed [DATA_W-1:0] data;
   } outcome_type;

   // One row of the directed table: a request repeated reps times (value counts up),
   // with an outcome typed in when fixed is set, else left to the queue shadow.
   typedef struct packed {
      logic                     op;
      logic [QID_W-1:0]         qid;
      logic signed [DATA_W-1:0] value;
      logic [4:0]               reps;
      logic                     fixed;
      outcome_type              outcome;
   } table_row_type;

   // Who idles how often: sender 17 / receiver 53, the reverse, then no idling.
   typedef enum logic [1:0] {
      GAPS_SENDER_LIGHT,
      GAPS_SENDER_HEAVY,
      GAPS_NONE
   } gap_mode_type;

   localparam outcome_type NO_DATA_OK    = '{STATUS_OK,    32'sd0};
   localparam outcome_type NO_DATA_FULL  = '{STATUS_FULL,  32'sd0};
   localparam outcome_type NO_DATA_EMPTY = '{STATUS_EMPTY, 32'sd0};

   localparam table_row_type DIRECTED [NUM_ROWS] = '{
      // Dequeue right after reset finds queue 0 empty.
      '{OP_DEQ, 2'd0, 32'sd0,         5'd1,  1'b1, NO_DATA_EMPTY},
      // Push both signed extremes through queue 0 and drain it again.
      '{OP_ENQ, 2'd0, 32'h7FFF_FFFF,  5'd1,  1'b1, NO_DATA_OK},
      '{OP_ENQ, 2'd0, 32'h8000_0000,  5'd1,  1'b1, NO_DATA_OK},
      '{OP_DEQ, 2'd0, 32'sd0,         5'd1,  1'b1, '{STATUS_OK, 32'h7FFF_FFFF}},
      '{OP_DEQ, 2'd0, 32'sd0,         5'd1,  1'b1, '{STATUS_OK, 32'h8000_0000}},
      '{OP_DEQ, 2'd0, 32'sd0,         5'd1,  1'b1, NO_DATA_EMPTY},
      // Highest queue number: one word in, one word out, then empty.
      '{OP_ENQ, 2'd3, 32'sd0,         5'd1,  1'b1, NO_DATA_OK},
      '{OP_DEQ, 2'd3, 32'sd0,         5'd1,  1'b1, NO_DATA_OK},
      '{OP_DEQ, 2'd3, 32'sd0,         5'd1,  1'b1, NO_DATA_EMPTY},
      // Fill queue 2 to the brim (values run across -1 and 0), then overflow it.
      '{OP_ENQ, 2'd2, 32'hFFFF_FFF8,  5'd16, 1'b0, NO_DATA_OK},
      '{OP_ENQ, 2'd2, 32'h5555_5555,  5'd1,  1'b1, NO_DATA_FULL},
      // Free one slot, let the tail wrap to the segment start, and hit full again.
      '{OP_DEQ, 2'd2, 32'sd0,         5'd1,  1'b0, NO_DATA_OK},
      '{OP_ENQ, 2'd2, 32'hAAAA_AAAA,  5'd1,  1'b0, NO_DATA_OK},
      '{OP_ENQ, 2'd2, 32'sd0,         5'd1,  1'b1, NO_DATA_FULL}
   };

   logic clock = 1'b0;
   logic reset;

   mqs_req_if req_bus ();
   mqs_rsp_if rsp_bus ();

   multi_queue_shared_store_top #(
      .NUM_QUEUES (NUM_QUEUES),
      .SEG_DEPTH  (SEG_DEPTH)
   ) DUT (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_bus),
      .rsp_if (rsp_bus)
   );

   always #1 clock = ~clock;

   // Shadow of the queues: store words, head and tail offsets, occupied flags.
   logic signed [DATA_W-1:0] shadow_store [NUM_QUEUES*SEG_DEPTH];
   int unsigned              head_pos     [NUM_QUEUES];
   int unsigned              tail_pos     [NUM_QUEUES];
   bit                       occupied     [NUM_QUEUES];

   outcome_type  queued_outcomes [$];
   int           error_count   = 0;
   int           stall_cycles  = 0;
   gap_mode_type gap_mode      = GAPS_SENDER_LIGHT;
   bit           hold_off_req  = 1'b0;
   outcome_type  oldest;

   // Advance an offset by one, wrapping inside the segment.
   function automatic int unsigned seg_next(input int unsigned off);
      return (off + 1 >= SEG_DEPTH) ? 0 : off + 1;
   endfunction

   // Apply one operation to the shadow queues and return the response it earns.
   function automatic outcome_type apply_queue_op(input logic op, input logic [QID_W-1:0] qid,
                                                  input logic signed [DATA_W-1:0] value);
      outcome_type res;
      int unsigned q;
      int unsigned base;
      res  = NO_DATA_OK;
      q    = qid;
      base = q * SEG_DEPTH;
      if (q >= NUM_QUEUES) begin
         res.status = (op == OP_ENQ) ? STATUS_FULL : STATUS_EMPTY;
      end else if (op == OP_ENQ) begin
         if (!occupied[q]) begin
            // First word of an empty queue always lands at offset 0.
            head_pos[q] = 0;
            tail_pos[q] = 0;
            occupied[q] = 1'b1;
            shadow_store[base] = value;
         end else if (seg_next(tail_pos[q]) == head_pos[q]) begin
            res.status = STATUS_FULL;
         end else begin
            tail_pos[q] = seg_next(tail_pos[q]);
            shadow_store[base + tail_pos[q]] = value;
         end
      end else begin
         if (!occupied[q]) begin
            res.status = STATUS_EMPTY;
         end else begin
            res.data = shadow_store[base + head_pos[q]];
            if (head_pos[q] == tail_pos[q]) begin
               // Last word taken: the queue empties and both offsets rewind.
               occupied[q] = 1'b0;
               head_pos[q] = 0;
               tail_pos[q] = 0;
            end else begin
               head_pos[q] = seg_next(head_pos[q]);
            end
         end
      end
      return res;
   endfunction

   // Decide whether one side idles this cycle.
   function automatic bit roll_gap(input int pct);
      return $urandom_range(99) < pct;
   endfunction

   // Offer one request beat, hold it until accepted, and queue its outcome.
   task automatic send_beat(input logic op, input logic [QID_W-1:0] qid,
                            input logic signed [DATA_W-1:0] value,
                            input bit fixed, input outcome_type fixed_outcome);
      outcome_type predicted;
      int          pct;
      case (gap_mode)
         GAPS_SENDER_LIGHT: pct = 17;
         GAPS_SENDER_HEAVY: pct = 53;
         default:           pct = 0;
      endcase
      // Drop valid for the idle cycles, if any, before this beat.
      while (roll_gap(pct)) begin
         req_bus.valid = 1'b0;
         @(negedge clock);
      end
      req_bus.valid    = 1'b1;
      req_bus.op       = op;
      req_bus.queue_id = qid;
      req_bus.value    = value;
      // Hold the beat until an edge finds ready high.
      do @(posedge clock); while (!req_bus.ready);
      predicted = apply_queue_op(op, qid, value);
      queued_outcomes.push_back(fixed ? fixed_outcome : predicted);
      @(negedge clock);
   endtask

   // Response side: drive ready at the falling edge, idling as the current mode asks,
   // and hold off for a long stretch once when the stimulus asks for it.
   initial begin
      int pct;
      rsp_bus.ready = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if (hold_off_req) begin
            hold_off_req  = 1'b0;
            rsp_bus.ready = 1'b0;
            repeat (HOLD_OFF_CYCLES) @(negedge clock);
         end
         case (gap_mode)
            GAPS_SENDER_LIGHT: pct = 53;
            GAPS_SENDER_HEAVY: pct = 17;
            default:           pct = 0;
         endcase
         rsp_bus.ready = !roll_gap(pct);
         @(negedge clock);
      end
   end

   // Check each response beat against the oldest outcome waiting, and watch for a hang.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (queued_outcomes.size() == 0) begin
               $error("response beat with no outcome waiting: status %0d data %0d",
                      rsp_bus.status, rsp_bus.data);
               error_count++;
            end else begin
               oldest = queued_outcomes.pop_front();
               if (rsp_bus.status !== oldest.status) begin
                  $error("status: expected %0d, got %0d", oldest.status, rsp_bus.status);
                  error_count++;
               end
               if (rsp_bus.data !== oldest.data) begin
                  $error("data: expected %0d, got %0d", oldest.data, rsp_bus.data);
                  error_count++;
               end
            end
         end
         // Count edges where neither channel moves a beat.
         if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
            stall_cycles = 0;
         else
            stall_cycles++;
         if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
         end
      end
   end

   // Stimulus: reset, the directed table, then three stretches of random traffic.
   initial begin
      int                       enq_pct;
      int                       focus_queue;
      bit                       focused;
      logic                     op;
      logic [QID_W-1:0]         qid;
      logic signed [DATA_W-1:0] value;

      reset            = 1'b1;
      req_bus.valid    = 1'b0;
      req_bus.op       = OP_ENQ;
      req_bus.queue_id = '0;
      req_bus.value    = '0;
      enq_pct          = 50;
      focus_queue      = 0;
      focused          = 1'b0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Walk the table; repeated rows count the value up from the row's base.
      foreach (DIRECTED[r]) begin
         for (int k = 0; k < DIRECTED[r].reps; k++)
            send_beat(DIRECTED[r].op, DIRECTED[r].qid, DIRECTED[r].value + k,
                      DIRECTED[r].fixed, DIRECTED[r].outcome);
      end

      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n < RANDOM_ITEMS / 3)
            gap_mode = GAPS_SENDER_LIGHT;
         else if (n < 2 * RANDOM_ITEMS / 3)
            gap_mode = GAPS_SENDER_HEAVY;
         else
            gap_mode = GAPS_NONE;
         // Ask for the long hold-off once the sender no longer idles, so the block backs up.
         if (n == 2 * RANDOM_ITEMS / 3 + 50)
            hold_off_req = 1'b1;
         // Shift the mix every few dozen beats: fill-heavy, drain-heavy or balanced,
         // often aimed at one queue so full and empty both come up regularly.
         if (n % 40 == 0) begin
            case ($urandom_range(2))
               0:       enq_pct = 85;
               1:       enq_pct = 15;
               default: enq_pct = 50;
            endcase
            focused     = $urandom_range(1);
            focus_queue = $urandom_range(NUM_QUEUES - 1);
         end
         op  = ($urandom_range(99) < enq_pct) ? OP_ENQ : OP_DEQ;
         qid = (focused && $urandom_range(9) < 7) ? QID_W'(focus_queue)
                                                  : QID_W'($urandom_range(NUM_QUEUES - 1));
         case ($urandom_range(7))
            0:       value = 32'h7FFF_FFFF;
            1:       value = 32'h8000_0000;
            2:       value = ($urandom_range(1) == 1) ? 32'sd0 : -32'sd1;
            default: value = $urandom;
         endcase
         send_beat(op, qid, value, 1'b0, NO_DATA_OK);
      end
      req_bus.valid = 1'b0;

      // Drain: wait for every outcome, then give the pipeline time to show any extra beat.
      while (queued_outcomes.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (error_count == 0 && queued_outcomes.size() == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule

/* multi_queue_shared_store_top.f */
design/mqs_pkg.sv
design/mqs_req_if.sv
design/mqs_rsp_if.sv
design/mqs_ctrl.sv
design/mqs_datapath.sv
design/multi_queue_shared_store_top.sv
dv/tb_multi_queue_shared_store_top.sv
